### hw/rtl/pfe_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// No dependencies; imported by the top level and by the checker.
package pfe_pkg;

   localparam int unsigned STATUS_W = 3;
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned RESULT_W = 32;

   // completion codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNBALANCED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZERO    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd4;

   // character codes
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_RDREQ = 9'b000000010,
      S_LOAD  = 9'b000000100,
      S_MUL   = 9'b000001000,
      S_NEGN  = 9'b000010000,
      S_NEGD  = 9'b000100000,
      S_DIV   = 9'b001000000,
      S_NEGQ  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

endpackage

### hw/rtl/pfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the operand stack below the top entry.
module pfe_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pfe_alu.sv
// Shared add/subtract unit: sum = x + y, or x - y when inv is set.
// No dependencies; used for add, subtract, negate, multiply and divide steps.
module pfe_alu #(
   parameter int unsigned WIDTH = 33
) (
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic             inv,
   output logic [WIDTH-1:0] sum
);

   logic [WIDTH-1:0] y_mod;

   assign y_mod = y ^ {WIDTH{inv}};
   assign sum   = x + y_mod + WIDTH'(inv);

endmodule

### hw/rtl/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator: sequencer, operand registers.
// Depends on pfe_pkg, pfe_ram (operand stack) and pfe_alu (shared adder).
//
//   channel | dir | beat contents                                   | handshake
//   --------+-----+-------------------------------------------------+-------------------
//   req     | in  | tdata[7:0] char_code, tlast end_of_input        | req_tvalid/tready
//   rsp     | out | tdata[31:0] result_value, [34:32] status        | rsp_tvalid/tready
//
// Digits and separators are taken in S_IDLE. + and - go through accept, stack read
// and execute; * adds a shift-add loop, / adds operand negation, a restoring-divide
// loop and quotient negation; the shared adder does one step of either loop per cycle.
// A last beat goes to S_DONE to post the result; if the previous result is still
// unaccepted the sequencer waits there, while the result register holds steady.
// Reset (synchronous) empties the stack, literal and error state; stack RAM
// contents are left as they are and never read before being written.
module postfix_expression_evaluator #(
   parameter int unsigned STACK_DEPTH = 32,
   parameter int unsigned DATA_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] result_value, [34:32] status, [39:35] zero
);

   import pfe_pkg::*;

   localparam int unsigned W    = DATA_WIDTH;
   localparam int unsigned AW   = $clog2(STACK_DEPTH);
   localparam int unsigned CW   = $clog2(STACK_DEPTH + 1);
   localparam int unsigned ITW  = $clog2(DATA_WIDTH);

   // sequencer and control
   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   in_lit_ff, in_lit_in;
   logic [STATUS_W-1:0]    err_ff, err_in;
   op_type                 op_ff, op_in;
   logic                   last_ff, last_in;
   logic [ITW-1:0]         iter_ff, iter_in;
   logic                   negq_ff, negq_in;

   // datapath
   logic [W-1:0]           acc_ff, acc_in;
   logic [W-1:0]           tos_ff, tos_in;
   logic [W-1:0]           a_ff, a_in;    // multiplicand / dividend, then quotient
   logic [W-1:0]           b_ff, b_in;    // multiplier / divisor
   logic [W-1:0]           p_ff, p_in;    // product / remainder

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   // stack RAM
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr, ram_raddr;
   logic [W-1:0]           ram_rdata;
   logic [CW-1:0]          cnt_m1, cnt_m2;

   // shared adder
   logic [W:0]             alu_x, alu_y, alu_sum;
   logic                   alu_inv;

   // beat decode
   logic                   req_fire, is_digit, is_op;
   op_type                 dec_op;
   logic [W-1:0]           acc_next, push_val;
   logic                   do_push, push_full;
   logic [63:0]            tos_ext;

   assign req_fire = req_tvalid && req_tready;
   assign is_digit = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);
   assign cnt_m1   = count_ff - CW'(1);
   assign cnt_m2   = count_ff - CW'(2);
   assign tos_ext  = 64'($signed(tos_ff));

   // acc * 10 + digit as two shifted copies plus the digit
   assign acc_next = (acc_ff << 3) + (acc_ff << 1) + W'(req_tdata[3:0]);

   always_comb begin
      is_op  = 1'b1;
      dec_op = OP_ADD;
      case (req_tdata)
         CH_PLUS:  dec_op = OP_ADD;
         CH_MINUS: dec_op = OP_SUB;
         CH_STAR:  dec_op = OP_MUL;
         CH_SLASH: dec_op = OP_DIV;
         default:  is_op  = 1'b0;
      endcase
   end

   // push a finished literal on this beat: on any non-digit beat after digits, or on a
   // last digit
   assign push_val  = is_digit ? acc_next : acc_ff;
   assign do_push   = req_fire && state_ff == S_IDLE && err_ff == ST_OK &&
                      (is_digit ? req_tlast : in_lit_ff);
   assign push_full = count_ff == CW'(STACK_DEPTH);

   assign ram_we    = do_push && !push_full && count_ff != '0;
   assign ram_waddr = cnt_m1[AW-1:0];
   assign ram_raddr = cnt_m2[AW-1:0];

   pfe_ram #(
      .WIDTH (W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (tos_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // operand select for the shared adder
   always_comb begin
      alu_x   = '0;
      alu_y   = '0;
      alu_inv = 1'b0;
      case (state_ff)
         S_LOAD: begin
            alu_x   = {1'b0, ram_rdata};
            alu_y   = {1'b0, tos_ff};
            alu_inv = op_ff == OP_SUB;
         end
         S_MUL: begin
            alu_x = {1'b0, p_ff};
            alu_y = {1'b0, a_ff};
         end
         S_NEGN: begin
            alu_y   = {1'b0, a_ff};
            alu_inv = 1'b1;
         end
         S_NEGD: begin
            alu_y   = {1'b0, b_ff};
            alu_inv = 1'b1;
         end
         S_DIV: begin
            alu_x   = {p_ff, a_ff[W-1]};
            alu_y   = {1'b0, b_ff};
            alu_inv = 1'b1;
         end
         S_NEGQ: begin
            alu_y   = {1'b0, a_ff};
            alu_inv = 1'b1;
         end
         default: begin
            alu_x = '0;
         end
      endcase
   end

   pfe_alu #(
      .WIDTH (W + 1)
   ) u_alu (
      .x   (alu_x),
      .y   (alu_y),
      .inv (alu_inv),
      .sum (alu_sum)
   );

   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      in_lit_in     = in_lit_ff;
      err_in        = err_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      iter_in       = iter_ff;
      negq_in       = negq_ff;
      acc_in        = acc_ff;
      tos_in        = tos_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      p_in          = p_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in   = dec_op;
               last_in = req_tlast;
               if (err_ff == ST_OK) begin
                  if (is_digit) begin
                     acc_in    = acc_next;
                     in_lit_in = 1'b1;
                  end else if (in_lit_ff) begin
                     acc_in    = '0;
                     in_lit_in = 1'b0;
                  end
                  if (do_push) begin
                     if (push_full) begin
                        err_in = ST_OVERFLOW;
                     end else begin
                        tos_in   = push_val;
                        count_in = count_ff + CW'(1);
                     end
                  end
               end
               if (err_ff == ST_OK && !is_digit && is_op && !(do_push && push_full)) begin
                  state_in = S_RDREQ;
               end else if (req_tlast) begin
                  state_in = S_DONE;
               end
            end
         end
         S_RDREQ: begin
            // read address count-2 is on the RAM port this cycle
            if (count_ff < CW'(2)) begin
               err_in   = ST_UNDERFLOW;
               state_in = last_ff ? S_DONE : S_IDLE;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            case (op_ff)
               OP_ADD, OP_SUB: begin
                  tos_in   = alu_sum[W-1:0];
                  count_in = cnt_m1;
                  state_in = last_ff ? S_DONE : S_IDLE;
               end
               OP_MUL: begin
                  a_in     = ram_rdata;
                  b_in     = tos_ff;
                  p_in     = '0;
                  iter_in  = '0;
                  state_in = S_MUL;
               end
               OP_DIV: begin
                  if (tos_ff == '0) begin
                     err_in   = ST_DIVZERO;
                     state_in = last_ff ? S_DONE : S_IDLE;
                  end else begin
                     a_in     = ram_rdata;
                     b_in     = tos_ff;
                     negq_in  = ram_rdata[W-1] ^ tos_ff[W-1];
                     state_in = S_NEGN;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_MUL: begin
            if (b_ff[0]) begin
               p_in = alu_sum[W-1:0];
            end
            a_in    = a_ff << 1;
            b_in    = b_ff >> 1;
            iter_in = iter_ff + ITW'(1);
            if (iter_ff == ITW'(W - 1)) begin
               tos_in   = b_ff[0] ? alu_sum[W-1:0] : p_ff;
               count_in = cnt_m1;
               state_in = last_ff ? S_DONE : S_IDLE;
            end
         end
         S_NEGN: begin
            if (a_ff[W-1]) begin
               a_in = alu_sum[W-1:0];
            end
            state_in = S_NEGD;
         end
         S_NEGD: begin
            if (b_ff[W-1]) begin
               b_in = alu_sum[W-1:0];
            end
            p_in     = '0;
            iter_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring step: keep the difference when it did not borrow
            if (!alu_sum[W]) begin
               p_in = alu_sum[W-1:0];
            end else begin
               p_in = alu_x[W-1:0];
            end
            a_in    = {a_ff[W-2:0], !alu_sum[W]};
            iter_in = iter_ff + ITW'(1);
            if (iter_ff == ITW'(W - 1)) begin
               state_in = S_NEGQ;
            end
         end
         S_NEGQ: begin
            tos_in   = negq_ff ? alu_sum[W-1:0] : a_ff;
            count_in = cnt_m1;
            state_in = last_ff ? S_DONE : S_IDLE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (err_ff != ST_OK) begin
                  rsp_status_in = err_ff;
                  rsp_value_in  = '0;
               end else if (count_ff == CW'(1)) begin
                  rsp_status_in = ST_OK;
                  rsp_value_in  = tos_ext[RESULT_W-1:0];
               end else begin
                  rsp_status_in = ST_UNBALANCED;
                  rsp_value_in  = '0;
               end
               count_in  = '0;
               acc_in    = '0;
               in_lit_in = 1'b0;
               err_in    = ST_OK;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         in_lit_ff    <= 1'b0;
         err_ff       <= ST_OK;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         in_lit_ff    <= in_lit_in;
         err_ff       <= err_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      last_ff       <= last_in;
      iter_ff       <= iter_in;
      negq_ff       <= negq_in;
      tos_ff        <= tos_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      p_ff          <= p_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_status_ff, rsp_value_ff};

endmodule

### hw/rtl/pfe_checker.sv
// Port-level checks for the postfix expression evaluator, bound to the top.
// Depends on pfe_pkg for status codes and character codes.
module pfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   import pfe_pkg::*;

   // a result beat waiting for the sink keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[34:32] == ST_OK || rsp_tdata[34:32] == ST_UNDERFLOW ||
                      rsp_tdata[34:32] == ST_UNBALANCED || rsp_tdata[34:32] == ST_DIVZERO ||
                      rsp_tdata[34:32] == ST_OVERFLOW))
      else $error("status code out of range");

   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34:32] != ST_OK |-> rsp_tdata[31:0] == 32'd0)
      else $error("nonzero value with error status");

   // the evaluator is ready again in the cycle after a non-last digit beat
   a_digit_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast &&
      req_tdata >= CH_ZERO && req_tdata <= CH_NINE |=> req_tready)
      else $error("not ready after a digit beat");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
